// ===== rtl/i2c_bit_level_master_macros.svh =====
// ----------------------------------------------------------------------------
// I2C bit-level master assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define I2CBLM_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define I2CBLM_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define I2CBLM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/i2cblm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Command codes and fixed constants of the bit-level bus sequencer.
// ----------------------------------------------------------------------------
package i2cblm_pkg;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4,
		CMD_ACK   = 3'd5
	} cmd_t;

	localparam logic [15:0] PHASE_TICKS_RESET = 16'd500;
	localparam logic [2:0]  LAST_BIT          = 3'd7;

	localparam logic [2:0]  STEP_0 = 3'd0;
	localparam logic [2:0]  STEP_1 = 3'd1;
	localparam logic [2:0]  STEP_2 = 3'd2;
	localparam logic [2:0]  STEP_3 = 3'd3;
	localparam logic [2:0]  STEP_4 = 3'd4;

endpackage

// ===== rtl/i2c_bit_level_master.sv =====
// The result of an accepted transaction is registered and valid in the cycle after it is accepted.
// Throughput: one transaction per cycle while results are taken; the single state update is the only loop.
// A new transaction is accepted whenever the result register is empty or being taken.
// Reset (arst_n low, asynchronous) leaves the sequencer idle, SCL and SDA high and driven,
// the phase length at 500 ticks and no result pending.
// ----------------------------------------------------------------------------
// I2C bit-level master
// Steps the bus phase sequencer by one tick per transaction and returns the line
// levels and status after that tick.
// ----------------------------------------------------------------------------
`include "i2c_bit_level_master_macros.svh"

module i2c_bit_level_master #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [15:0] cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [7:0]  write_data,
	input  logic        ack_level,
	input  logic        sda_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_level,
	output logic        sda_level,
	output logic        sda_enable,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        ack_seen
);

	localparam int LW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	logic [15:0]            phase_ticks_q;
	i2cblm_pkg::cmd_t       cmd_q, cmd_d;
	logic [2:0]             step_q, step_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic [2:0]             bit_q, bit_d;
	logic [7:0]             shift_q, shift_d;
	logic                   scl_q, scl_d;
	logic                   sda_q, sda_d;
	logic                   en_q, en_d;
	logic                   ack_q, ack_d;
	logic [7:0]             last_q, last_d;
	logic                   done_q, done_d;
	logic                   out_valid_q;

	logic [LW-1:0]          lim_ext;
	logic [TIMER_WIDTH-1:0] limit;
	logic                   busy;
	logic                   accept;
	logic                   start_cmd;
	logic                   phase_end;
	logic                   finish;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign busy     = (cmd_q != i2cblm_pkg::CMD_IDLE);

	always_comb begin
		lim_ext = LW'(phase_ticks_q);
		if (lim_ext == '0) begin
			lim_ext = LW'(1);
		end
		if (lim_ext > LW'({TIMER_WIDTH{1'b1}})) begin
			lim_ext = LW'({TIMER_WIDTH{1'b1}});
		end
		limit = lim_ext[TIMER_WIDTH-1:0];
	end

	assign start_cmd = !busy && (op >= 3'(i2cblm_pkg::CMD_START))
		&& (op <= 3'(i2cblm_pkg::CMD_ACK));
	assign phase_end = busy && !(timer_q < limit);

	always_comb begin
		unique case (cmd_q)
			i2cblm_pkg::CMD_START: finish = (step_q != i2cblm_pkg::STEP_0);
			i2cblm_pkg::CMD_STOP:  finish = (step_q >= i2cblm_pkg::STEP_2);
			i2cblm_pkg::CMD_ACK:   finish = (step_q != i2cblm_pkg::STEP_0);
			i2cblm_pkg::CMD_WRITE: finish = (step_q >= i2cblm_pkg::STEP_4);
			i2cblm_pkg::CMD_READ:  finish = (step_q != i2cblm_pkg::STEP_0)
				&& (bit_q >= i2cblm_pkg::LAST_BIT);
			default:               finish = 1'b1;
		endcase
	end

	// Next state of the sequencer: command, phase step, phase timer and done flag.
	always_comb begin
		cmd_d   = cmd_q;
		step_d  = step_q;
		timer_d = timer_q;
		done_d  = 1'b0;
		if (!busy) begin
			if (start_cmd) begin
				cmd_d   = i2cblm_pkg::cmd_t'(op);
				step_d  = i2cblm_pkg::STEP_0;
				timer_d = TIMER_WIDTH'(1);
			end
		end else if (!phase_end) begin
			timer_d = timer_q + TIMER_WIDTH'(1);
		end else begin
			timer_d = TIMER_WIDTH'(1);
			if (finish) begin
				cmd_d   = i2cblm_pkg::CMD_IDLE;
				step_d  = i2cblm_pkg::STEP_0;
				timer_d = '0;
				done_d  = 1'b1;
			end else begin
				unique case (cmd_q)
					i2cblm_pkg::CMD_WRITE: begin
						if (step_q == i2cblm_pkg::STEP_0) begin
							step_d = i2cblm_pkg::STEP_1;
						end else if (step_q == i2cblm_pkg::STEP_1) begin
							step_d = i2cblm_pkg::STEP_2;
						end else if (step_q == i2cblm_pkg::STEP_2) begin
							step_d = (bit_q < i2cblm_pkg::LAST_BIT) ? i2cblm_pkg::STEP_0
								: i2cblm_pkg::STEP_3;
						end else begin
							step_d = i2cblm_pkg::STEP_4;
						end
					end
					i2cblm_pkg::CMD_READ: begin
						step_d = (step_q == i2cblm_pkg::STEP_0) ? i2cblm_pkg::STEP_1
							: i2cblm_pkg::STEP_0;
					end
					default: begin
						step_d = step_q + 3'd1;
					end
				endcase
			end
		end
	end

	// Line levels, shift register, bit counter and captured status.
	always_comb begin
		bit_d   = bit_q;
		shift_d = shift_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		en_d    = en_q;
		ack_d   = ack_q;
		last_d  = last_q;
		if (start_cmd) begin
			bit_d = '0;
			unique case (op)
				3'(i2cblm_pkg::CMD_START): begin
					scl_d = 1'b1; sda_d = 1'b1; en_d = 1'b1;
				end
				3'(i2cblm_pkg::CMD_STOP): begin
					scl_d = 1'b1; sda_d = 1'b0; en_d = 1'b1;
				end
				3'(i2cblm_pkg::CMD_WRITE): begin
					shift_d = write_data;
					scl_d = 1'b0; sda_d = write_data[7]; en_d = 1'b1;
				end
				3'(i2cblm_pkg::CMD_READ): begin
					shift_d = '0;
					scl_d = 1'b1; sda_d = 1'b1; en_d = 1'b0;
				end
				default: begin
					scl_d = 1'b1; sda_d = ack_level; en_d = 1'b1;
				end
			endcase
		end else if (phase_end) begin
			unique case (cmd_q)
				i2cblm_pkg::CMD_START: begin
					if (step_q == i2cblm_pkg::STEP_0) begin
						sda_d = 1'b0;
					end else begin
						scl_d = 1'b0;
					end
				end
				i2cblm_pkg::CMD_STOP: begin
					if (step_q == i2cblm_pkg::STEP_0) begin
						sda_d = 1'b1;
					end else if (step_q == i2cblm_pkg::STEP_1) begin
						scl_d = 1'b0;
					end
				end
				i2cblm_pkg::CMD_ACK: begin
					if (step_q == i2cblm_pkg::STEP_0) begin
						scl_d = 1'b0;
						sda_d = 1'b1;
					end
				end
				i2cblm_pkg::CMD_WRITE: begin
					if (step_q == i2cblm_pkg::STEP_0) begin
						scl_d = 1'b1;
					end else if (step_q == i2cblm_pkg::STEP_1) begin
						scl_d = 1'b0;
					end else if (step_q == i2cblm_pkg::STEP_2) begin
						if (bit_q < i2cblm_pkg::LAST_BIT) begin
							bit_d   = bit_q + 3'd1;
							shift_d = {shift_q[6:0], 1'b0};
							sda_d   = shift_q[6];
						end else begin
							scl_d = 1'b1; sda_d = 1'b1; en_d = 1'b0;
						end
					end else if (step_q == i2cblm_pkg::STEP_3) begin
						ack_d = sda_sample;
					end else begin
						scl_d = 1'b0;
						en_d  = 1'b1;
					end
				end
				i2cblm_pkg::CMD_READ: begin
					if (step_q == i2cblm_pkg::STEP_0) begin
						shift_d = {shift_q[6:0], sda_sample};
						scl_d   = 1'b0;
					end else if (bit_q < i2cblm_pkg::LAST_BIT) begin
						bit_d = bit_q + 3'd1;
						scl_d = 1'b1;
					end else begin
						en_d   = 1'b1;
						last_d = shift_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cblm_pkg::PHASE_TICKS_RESET;
		end else if (cfg_write_en) begin
			phase_ticks_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= i2cblm_pkg::CMD_IDLE;
			step_q      <= '0;
			timer_q     <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			en_q        <= 1'b1;
			ack_q       <= 1'b0;
			last_q      <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cmd_q   <= cmd_d;
				step_q  <= step_d;
				timer_q <= timer_d;
				bit_q   <= bit_d;
				shift_q <= shift_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				en_q    <= en_d;
				ack_q   <= ack_d;
				last_q  <= last_d;
				done_q  <= done_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign scl_level  = scl_q;
	assign sda_level  = sda_q;
	assign sda_enable = en_q;
	assign busy_res   = busy;
	assign done_res   = done_q;
	assign read_data  = last_q;
	assign ack_seen   = ack_q;

	`I2CBLM_ASSERT_IMPLY(a_done_idle, done_q, !busy, "done reported while a command still runs")
	`I2CBLM_ASSERT_IMPLY(a_idle_timer, !busy, timer_q == '0, "phase timer not cleared while idle")
	`I2CBLM_ASSERT_IMPLY(a_stall_blocks, out_valid_q && !out_ready, !in_ready,
		"transaction accepted while the result is stalled")
	`I2CBLM_ASSERT_NEXT(a_result_follows, accept, out_valid_q,
		"accepted transaction produced no result")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master testbench
// A short table of directed ticks covers reset levels, unused and ignored
// commands, every command and the extremes of the phase length. Random ticks
// built from well-formed bus sequences then follow under several phase lengths.
// Each result is compared with the row's expected levels where a directed row gives
// them, else with a bus sequencer model kept in the testbench; in most phases the handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [2:0] OP_UNUSED_6 = 3'd6;
	localparam logic [2:0] OP_UNUSED_7 = 3'd7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES = 6;
	localparam int TICKS_PER_PHASE = 150;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] wd;
		logic       ackl;
		logic       sda;
	} tick_in_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       en;
		logic       busy;
		logic       done;
		logic [7:0] rd;
		logic       ack;
	} line_status_t;

	typedef struct packed {
		logic         cfg_wr;
		logic [15:0]  cfg_val;
		logic [2:0]   op;
		logic [7:0]   wd;
		logic         ackl;
		logic         sda;
		logic         typed;
		line_status_t want;
	} stim_row_t;

	localparam line_status_t LINES_RESET   = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
	localparam line_status_t LINES_START   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
	localparam line_status_t LINES_SDA_LOW = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
	localparam line_status_t LINES_READ    = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
	localparam line_status_t LINES_NONE    = '0;

	localparam int DIR_COUNT = 25;
	localparam stim_row_t DIR_ROWS [0:DIR_COUNT-1] = '{
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_IDLE,  8'h00, 1'b0, 1'b0, 1'b1, LINES_RESET},
		'{1'b0, 16'd0,    OP_UNUSED_6,           8'hFF, 1'b1, 1'b1, 1'b1, LINES_RESET},
		'{1'b0, 16'd0,    OP_UNUSED_7,           8'h00, 1'b0, 1'b1, 1'b1, LINES_RESET},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_START, 8'hFF, 1'b1, 1'b0, 1'b1, LINES_START},
		'{1'b1, 16'd0,    i2cblm_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_IDLE,  8'h00, 1'b0, 1'b0, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_ACK,   8'h5A, 1'b0, 1'b1, 1'b1, LINES_SDA_LOW},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_IDLE,  8'h00, 1'b1, 1'b1, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_IDLE,  8'h00, 1'b0, 1'b0, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_STOP,  8'hA5, 1'b1, 1'b0, 1'b1, LINES_SDA_LOW},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_ACK,   8'h00, 1'b1, 1'b1, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_READ,  8'hFF, 1'b0, 1'b0, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_IDLE,  8'h00, 1'b0, 1'b1, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_READ,  8'h00, 1'b1, 1'b1, 1'b1, LINES_READ},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_IDLE,  8'h00, 1'b0, 1'b1, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b0, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_IDLE,  8'hFF, 1'b0, 1'b0, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_STOP,  8'h00, 1'b0, 1'b1, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_IDLE,  8'h00, 1'b1, 1'b0, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    OP_UNUSED_7,           8'hFF, 1'b1, 1'b1, 1'b0, LINES_NONE},
		'{1'b1, 16'hFFFF, i2cblm_pkg::CMD_IDLE,  8'h00, 1'b0, 1'b1, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_IDLE,  8'h00, 1'b0, 1'b0, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 1'b0, LINES_NONE},
		'{1'b1, 16'd2,    i2cblm_pkg::CMD_IDLE,  8'h00, 1'b0, 1'b1, 1'b0, LINES_NONE},
		'{1'b0, 16'd0,    i2cblm_pkg::CMD_IDLE,  8'h00, 1'b0, 1'b0, 1'b0, LINES_NONE}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [15:0] cfg_write_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  op = '0;
	logic [7:0]  write_data = '0;
	logic        ack_level = 1'b0;
	logic        sda_sample = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        scl_level;
	logic        sda_level;
	logic        sda_enable;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_data;
	logic        ack_seen;

	i2c_bit_level_master DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.write_data     (write_data),
		.ack_level      (ack_level),
		.sda_sample     (sda_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.scl_level      (scl_level),
		.sda_level      (sda_level),
		.sda_enable     (sda_enable),
		.busy_res       (busy_res),
		.done_res       (done_res),
		.read_data      (read_data),
		.ack_seen       (ack_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Bus sequencer model state.
	i2cblm_pkg::cmd_t seq_cmd = i2cblm_pkg::CMD_IDLE;
	logic [2:0]  seq_step = i2cblm_pkg::STEP_0;
	logic [15:0] seq_timer = '0;
	logic [3:0]  seq_bit = '0;
	logic [7:0]  seq_shift = '0;
	logic        scl_q = 1'b1;
	logic        sda_q = 1'b1;
	logic        en_q = 1'b1;
	logic        ack_q = 1'b0;
	logic [7:0]  last_rd = '0;
	logic [15:0] tick_cfg = i2cblm_pkg::PHASE_TICKS_RESET;

	line_status_t expected_lines [$];
	int errors = 0;
	bit in_idle_on = 1'b1;
	bit out_idle_on = 1'b1;
	int bus_pos = 0;
	bit after_read = 1'b0;
	int idle_cycles = 0;

	function automatic logic phase_end(input logic sda_in);
		phase_end = 1'b0;
		case (seq_cmd)
			i2cblm_pkg::CMD_START: begin
				if (seq_step == i2cblm_pkg::STEP_0) begin
					sda_q = 1'b0;
					seq_step = i2cblm_pkg::STEP_1;
				end else begin
					scl_q = 1'b0;
					phase_end = 1'b1;
				end
			end
			i2cblm_pkg::CMD_STOP: begin
				if (seq_step == i2cblm_pkg::STEP_0) begin
					sda_q = 1'b1;
					seq_step = i2cblm_pkg::STEP_1;
				end else if (seq_step == i2cblm_pkg::STEP_1) begin
					scl_q = 1'b0;
					seq_step = i2cblm_pkg::STEP_2;
				end else begin
					phase_end = 1'b1;
				end
			end
			i2cblm_pkg::CMD_ACK: begin
				if (seq_step == i2cblm_pkg::STEP_0) begin
					scl_q = 1'b0;
					sda_q = 1'b1;
					seq_step = i2cblm_pkg::STEP_1;
				end else begin
					phase_end = 1'b1;
				end
			end
			i2cblm_pkg::CMD_WRITE: begin
				if (seq_step == i2cblm_pkg::STEP_0) begin
					scl_q = 1'b1;
					seq_step = i2cblm_pkg::STEP_1;
				end else if (seq_step == i2cblm_pkg::STEP_1) begin
					scl_q = 1'b0;
					seq_step = i2cblm_pkg::STEP_2;
				end else if (seq_step == i2cblm_pkg::STEP_2) begin
					if (seq_bit < i2cblm_pkg::LAST_BIT) begin
						seq_bit = seq_bit + 4'd1;
						seq_shift = {seq_shift[6:0], 1'b0};
						sda_q = seq_shift[7];
						seq_step = i2cblm_pkg::STEP_0;
					end else begin
						scl_q = 1'b1;
						sda_q = 1'b1;
						en_q = 1'b0;
						seq_step = i2cblm_pkg::STEP_3;
					end
				end else if (seq_step == i2cblm_pkg::STEP_3) begin
					ack_q = sda_in;
					seq_step = i2cblm_pkg::STEP_4;
				end else begin
					scl_q = 1'b0;
					en_q = 1'b1;
					phase_end = 1'b1;
				end
			end
			i2cblm_pkg::CMD_READ: begin
				if (seq_step == i2cblm_pkg::STEP_0) begin
					seq_shift = {seq_shift[6:0], sda_in};
					scl_q = 1'b0;
					seq_step = i2cblm_pkg::STEP_1;
				end else if (seq_bit < i2cblm_pkg::LAST_BIT) begin
					seq_bit = seq_bit + 4'd1;
					scl_q = 1'b1;
					seq_step = i2cblm_pkg::STEP_0;
				end else begin
					en_q = 1'b1;
					last_rd = seq_shift;
					phase_end = 1'b1;
				end
			end
			default: phase_end = 1'b1;
		endcase
	endfunction

	function automatic line_status_t bus_tick(input tick_in_t t);
		line_status_t r;
		logic fin;
		logic [15:0] lim;
		fin = 1'b0;
		lim = (tick_cfg == 16'd0) ? 16'd1 : tick_cfg;
		if (seq_cmd == i2cblm_pkg::CMD_IDLE) begin
			if (t.op >= i2cblm_pkg::CMD_START && t.op <= i2cblm_pkg::CMD_ACK) begin
				seq_cmd = i2cblm_pkg::cmd_t'(t.op);
				seq_step = i2cblm_pkg::STEP_0;
				seq_timer = 16'd1;
				seq_bit = '0;
				case (seq_cmd)
					i2cblm_pkg::CMD_START: {scl_q, sda_q, en_q} = 3'b111;
					i2cblm_pkg::CMD_STOP: {scl_q, sda_q, en_q} = 3'b101;
					i2cblm_pkg::CMD_WRITE: begin
						seq_shift = t.wd;
						{scl_q, sda_q, en_q} = {1'b0, t.wd[7], 1'b1};
					end
					i2cblm_pkg::CMD_READ: begin
						seq_shift = '0;
						{scl_q, sda_q, en_q} = 3'b110;
					end
					default: {scl_q, sda_q, en_q} = {1'b1, t.ackl, 1'b1};
				endcase
			end
		end else if (seq_timer < lim) begin
			seq_timer = seq_timer + 16'd1;
		end else begin
			seq_timer = 16'd1;
			if (phase_end(t.sda)) begin
				seq_cmd = i2cblm_pkg::CMD_IDLE;
				seq_step = i2cblm_pkg::STEP_0;
				seq_timer = '0;
				fin = 1'b1;
			end
		end
		r.scl = scl_q;
		r.sda = sda_q;
		r.en = en_q;
		r.busy = (seq_cmd != i2cblm_pkg::CMD_IDLE);
		r.done = fin;
		r.rd = last_rd;
		r.ack = ack_q;
		return r;
	endfunction

	// While the sequencer is idle, most commands follow a bus transfer:
	// start, address write, then writes or reads with an ack after each read, then stop.
	function automatic logic [2:0] pick_op();
		logic [2:0] c;
		if (seq_cmd != i2cblm_pkg::CMD_IDLE || $urandom_range(0, 99) < 15) begin
			c = 3'($urandom_range(0, 7));
			return c;
		end
		case (bus_pos)
			0: c = i2cblm_pkg::CMD_START;
			1: c = i2cblm_pkg::CMD_WRITE;
			default: begin
				if (after_read) begin
					c = i2cblm_pkg::CMD_ACK;
				end else begin
					case ($urandom_range(0, 3))
						0: c = i2cblm_pkg::CMD_STOP;
						1: c = i2cblm_pkg::CMD_WRITE;
						default: c = i2cblm_pkg::CMD_READ;
					endcase
				end
			end
		endcase
		after_read = (c == i2cblm_pkg::CMD_READ);
		bus_pos = (c == i2cblm_pkg::CMD_STOP) ? 0 : bus_pos + 1;
		return c;
	endfunction

	task automatic send_tick(input tick_in_t t, input logic typed, input line_status_t want);
		int gap;
		line_status_t got;
		gap = in_idle_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= t.op;
		write_data <= t.wd;
		ack_level <= t.ackl;
		sda_sample <= t.sda;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		got = bus_tick(t);
		expected_lines.push_back(typed ? want : got);
	endtask

	task automatic set_phase_ticks(input logic [15:0] value);
		in_valid <= 1'b0;
		while (expected_lines.size() != 0) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		tick_cfg = value;
	endtask

	task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	initial begin : stimulus
		tick_in_t t;
		logic [15:0] phase_len;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int row = 0; row < DIR_COUNT; row++) begin
			if (DIR_ROWS[row].cfg_wr)
				set_phase_ticks(DIR_ROWS[row].cfg_val);
			t = '{DIR_ROWS[row].op, DIR_ROWS[row].wd, DIR_ROWS[row].ackl, DIR_ROWS[row].sda};
			send_tick(t, DIR_ROWS[row].typed, DIR_ROWS[row].want);
		end
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			in_idle_on = (p != 0) && (p != 3);
			out_idle_on = (p != 0) && (p != 2);
			case (p)
				0: phase_len = 16'd1;
				1: phase_len = 16'd0;
				2: phase_len = 16'd2;
				3: phase_len = 16'($urandom_range(1, 4));
				4: phase_len = 16'd3;
				default: phase_len = 16'($urandom_range(1, 8));
			endcase
			set_phase_ticks(phase_len);
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				t.op = pick_op();
				t.wd = 8'($urandom_range(0, 255));
				t.ackl = 1'($urandom_range(0, 1));
				t.sda = 1'($urandom_range(0, 1));
				send_tick(t, 1'b0, LINES_NONE);
			end
		end
		in_valid <= 1'b0;
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("i2c_bit_level_master: match");
		else
			$display("i2c_bit_level_master: mismatch");
		$finish;
	end

	initial begin : result_sink
		int gap;
		line_status_t got;
		line_status_t want;
		forever begin
			gap = out_idle_on ? $urandom_range(0, 14) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			got = '{scl_level, sda_level, sda_enable, busy_res, done_res, read_data, ack_seen};
			if (expected_lines.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected transaction, expected none actual %h",
					$time, got);
			end else begin
				want = expected_lines.pop_front();
				cmp_field("scl_level", 8'(want.scl), 8'(got.scl));
				cmp_field("sda_level", 8'(want.sda), 8'(got.sda));
				cmp_field("sda_enable", 8'(want.en), 8'(got.en));
				cmp_field("busy_res", 8'(want.busy), 8'(got.busy));
				cmp_field("done_res", 8'(want.done), 8'(got.done));
				cmp_field("read_data", want.rd, got.rd);
				cmp_field("ack_seen", 8'(want.ack), 8'(got.ack));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_ready === 1'b1) ||
				(out_valid === 1'b1 && out_ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
			$display("i2c_bit_level_master: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/i2cblm_pkg.sv
rtl/i2c_bit_level_master.sv
dv/tb_top.sv
